FILE: hw/rtl/poc_pkg.sv
// Shared types, constants and the arctangent table for the patch orientation block.
`timescale 1ns / 1ps

package poc_pkg;

    // Field widths
    localparam int PIX_W    = 8;
    localparam int OFS_W    = 5;
    localparam int MOM_W    = 23;
    localparam int ANG_W    = 16;
    localparam int ZACC_W   = 17;
    localparam int XY_W     = MOM_W + 3;
    localparam int PROD_W   = OFS_W + PIX_W + 1;
    localparam int IN_W     = 24;
    localparam int OUT_W    = 64;
    localparam int ATAN_W   = 13;

    // Patch radius: pixels further out than this are ignored
    localparam int HALF_PATCH = 15;

    // Default number of CORDIC iterations
    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic signed [MOM_W:0] MOM_MAX = 24'sd4194303;
    localparam logic signed [MOM_W:0] MOM_MIN = -24'sd4194304;

    localparam logic signed [ZACC_W-1:0] ANG_PI      = 17'sd25736;
    localparam logic signed [ZACC_W-1:0] ANG_HALF_PI = 17'sd12868;

    typedef enum logic [3:0] {
        S_ACCUM  = 4'b0001,
        S_LOAD   = 4'b0010,
        S_ITER   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    typedef struct packed {
        logic accept;     // pixel request taken this cycle
        logic load;       // latch moments, pre-rotate, clear accumulators
        logic iter;       // run one CORDIC micro-rotation
        logic write_out;  // move the angle and moments into the output register
    } t_cmd;

    typedef struct packed {
        logic iter_last;  // current micro-rotation is the final one
        logic out_free;   // output register can take a result this cycle
    } t_status;

    // atan(2^-i) in Q3.13, rounded half up
    function automatic logic [ATAN_W-1:0] atan_entry(input int i);
        logic [ATAN_W-1:0] v;
        begin
            case (i)
                0:  v = 13'd6434;
                1:  v = 13'd3798;
                2:  v = 13'd2007;
                3:  v = 13'd1019;
                4:  v = 13'd511;
                5:  v = 13'd256;
                6:  v = 13'd128;
                7:  v = 13'd64;
                8:  v = 13'd32;
                9:  v = 13'd16;
                10: v = 13'd8;
                11: v = 13'd4;
                12: v = 13'd2;
                13: v = 13'd1;
                14: v = 13'd1;
                default: v = 13'd0;
            endcase
            return v;
        end
    endfunction

endpackage

FILE: hw/rtl/patch_orientation_centroid.sv
// Top level of the intensity-centroid patch orientation block.
`timescale 1ns / 1ps

// Takes the pixels of one keypoint patch, one request per cycle, each with its signed
// column and row offset from the patch centre, and accumulates the first moments
// m10 = sum(col * pixel) and m01 = sum(row * pixel), each saturating at 23 bits. Pixels
// whose offset exceeds the patch radius are ignored, but their tlast still counts. On the
// request marked tlast the block stops taking pixels while it works on the patch: a load
// step latches the moments, pre-rotates a left-half vector by a quarter turn and clears
// the accumulators, CORDIC_STEPS iterations run the shared shift-and-add vectoring unit
// one micro-rotation per cycle, and a finish step moves the result into the output
// register. The result carries atan2(m01, m10) as signed Q3.13 radians clamped to
// [-pi, pi] (zero when both moments are zero) and both moments. A result waiting in
// the output register does not block the next patch's pixels; the block only holds in its
// final cycle if the previous result has still not been taken.
module patch_orientation_centroid
    import poc_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Pixel requests
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // [7:0] pixel, [12:8] col_offset, [17:13] row_offset
    input  logic             s_axis_tlast,   // last_pixel
    // Orientation results
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // [15:0] angle, [38:16] moment_x, [61:39] moment_y
);

    t_cmd    cmd;
    t_status status;

    logic signed [ANG_W-1:0] angle;
    logic signed [MOM_W-1:0] moment_x;
    logic signed [MOM_W-1:0] moment_y;

    // Sequence accumulation, CORDIC run and hand-off
    poc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Unpack the request fields straight into the datapath
    poc_dp #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_pixel      (s_axis_tdata[7:0]),
        .i_col_offset ($signed(s_axis_tdata[12:8])),
        .i_row_offset ($signed(s_axis_tdata[17:13])),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_angle      (angle),
        .o_moment_x   (moment_x),
        .o_moment_y   (moment_y)
    );

    // Pack the result, pad to whole bytes
    assign m_axis_tdata = {2'b00, moment_y, moment_x, angle};

    // A final pixel hands the block over to the CORDIC: no pixel is taken next cycle
    a_stop_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("pixel request taken while the CORDIC was starting");

    // The angle always lies within [-pi, pi]
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'sd25736 &&
                           $signed(m_axis_tdata[15:0]) >= -16'sd25736))
        else $error("angle outside [-pi, pi]");

    // A patch with zero moments reports a zero angle
    a_zero_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[61:16] == 46'd0) |-> (m_axis_tdata[15:0] == 16'd0))
        else $error("non-zero angle for a zero moment vector");

endmodule

FILE: hw/rtl/poc_ctrl.sv
// Sequencing state machine: pixel accumulation, CORDIC run and result hand-off.
`timescale 1ns / 1ps

module poc_ctrl
    import poc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_ACCUM: begin
                if (i_in_valid && i_in_last) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_ITER;
            end
            S_ITER: begin
                if (i_status.iter_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    n_state = S_ACCUM;
                end
            end
            default: begin
                n_state = S_ACCUM;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACCUM;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready      = (r_state == S_ACCUM);
    assign o_cmd.accept    = (r_state == S_ACCUM) && i_in_valid;
    assign o_cmd.load      = (r_state == S_LOAD);
    assign o_cmd.iter      = (r_state == S_ITER);
    assign o_cmd.write_out = (r_state == S_FINISH) && i_status.out_free;

endmodule

FILE: hw/rtl/poc_dp.sv
// Moment accumulators, iterative CORDIC and output register.
`timescale 1ns / 1ps

module poc_dp
    import poc_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  logic [PIX_W-1:0]        i_pixel,
    input  logic signed [OFS_W-1:0] i_col_offset,
    input  logic signed [OFS_W-1:0] i_row_offset,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [ANG_W-1:0] o_angle,
    output logic signed [MOM_W-1:0] o_moment_x,
    output logic signed [MOM_W-1:0] o_moment_y
);

    localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_STEPS - 1);

    // Accumulators
    logic signed [MOM_W-1:0]  r_sum_x, n_sum_x;
    logic signed [MOM_W-1:0]  r_sum_y, n_sum_y;
    logic                     in_patch;
    logic signed [PROD_W-1:0] prod_x, prod_y;
    logic signed [MOM_W:0]    wide_x, wide_y;

    // CORDIC
    logic signed [XY_W-1:0]   r_x, n_x;
    logic signed [XY_W-1:0]   r_y, n_y;
    logic signed [ZACC_W-1:0] r_z, n_z;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_zero, n_zero;
    logic signed [MOM_W-1:0]  r_mom_x, n_mom_x;
    logic signed [MOM_W-1:0]  r_mom_y, n_mom_y;
    logic signed [XY_W-1:0]   sx, sy, xs, ys;
    logic signed [ZACC_W-1:0] step_ang;

    // Output register
    logic                     r_out_valid, n_out_valid;
    logic signed [ANG_W-1:0]  r_angle, n_angle;
    logic signed [MOM_W-1:0]  r_out_x, n_out_x;
    logic signed [MOM_W-1:0]  r_out_y, n_out_y;
    logic signed [ZACC_W-1:0] z_sat;

    function automatic logic signed [MOM_W-1:0] sat_mom(input logic signed [MOM_W:0] v);
        logic signed [MOM_W-1:0] r;
        begin
            if (v > MOM_MAX) begin
                r = MOM_MAX[MOM_W-1:0];
            end else if (v < MOM_MIN) begin
                r = MOM_MIN[MOM_W-1:0];
            end else begin
                r = v[MOM_W-1:0];
            end
            return r;
        end
    endfunction

    // Accumulate
    assign in_patch = (int'(i_col_offset) <= HALF_PATCH) && (int'(i_col_offset) >= -HALF_PATCH) &&
                      (int'(i_row_offset) <= HALF_PATCH) && (int'(i_row_offset) >= -HALF_PATCH);
    assign prod_x = PROD_W'(i_col_offset) * PROD_W'($signed({1'b0, i_pixel}));
    assign prod_y = PROD_W'(i_row_offset) * PROD_W'($signed({1'b0, i_pixel}));
    assign wide_x = (MOM_W+1)'(r_sum_x) + (MOM_W+1)'(prod_x);
    assign wide_y = (MOM_W+1)'(r_sum_y) + (MOM_W+1)'(prod_y);

    always_comb begin
        n_sum_x = r_sum_x;
        n_sum_y = r_sum_y;
        if (i_cmd.load) begin
            n_sum_x = '0;
            n_sum_y = '0;
        end else if (i_cmd.accept && in_patch) begin
            n_sum_x = sat_mom(wide_x);
            n_sum_y = sat_mom(wide_y);
        end
    end

    // CORDIC vectoring
    assign sx       = XY_W'(r_sum_x);
    assign sy       = XY_W'(r_sum_y);
    assign xs       = r_x >>> r_cnt;
    assign ys       = r_y >>> r_cnt;
    assign step_ang = $signed({{(ZACC_W-ATAN_W){1'b0}}, atan_entry(int'(r_cnt))});

    always_comb begin
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_cnt   = r_cnt;
        n_zero  = r_zero;
        n_mom_x = r_mom_x;
        n_mom_y = r_mom_y;
        if (i_cmd.load) begin
            n_mom_x = r_sum_x;
            n_mom_y = r_sum_y;
            n_zero  = (r_sum_x == '0) && (r_sum_y == '0);
            n_cnt   = '0;
            if (r_sum_x < 0) begin
                if (r_sum_y >= 0) begin
                    n_x = sy;
                    n_y = -sx;
                    n_z = ANG_HALF_PI;
                end else begin
                    n_x = -sy;
                    n_y = sx;
                    n_z = -ANG_HALF_PI;
                end
            end else begin
                n_x = sx;
                n_y = sy;
                n_z = '0;
            end
        end else if (i_cmd.iter) begin
            n_cnt = r_cnt + 1'b1;
            if (r_y >= 0) begin
                n_x = r_x + ys;
                n_y = r_y - xs;
                n_z = r_z + step_ang;
            end else begin
                n_x = r_x - ys;
                n_y = r_y + xs;
                n_z = r_z - step_ang;
            end
        end
    end

    // Output register
    always_comb begin
        if (r_z > ANG_PI) begin
            z_sat = ANG_PI;
        end else if (r_z < -ANG_PI) begin
            z_sat = -ANG_PI;
        end else begin
            z_sat = r_z;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_angle     = r_angle;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        if (i_cmd.write_out) begin
            n_out_valid = 1'b1;
            n_angle     = r_zero ? '0 : z_sat[ANG_W-1:0];
            n_out_x     = r_mom_x;
            n_out_y     = r_mom_y;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_sum_x     <= n_sum_x;
            r_sum_y     <= n_sum_y;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_y     <= n_y;
        r_z     <= n_z;
        r_zero  <= n_zero;
        r_mom_x <= n_mom_x;
        r_mom_y <= n_mom_y;
        r_angle <= n_angle;
        r_out_x <= n_out_x;
        r_out_y <= n_out_y;
    end

    assign o_status.iter_last = (r_cnt == CNT_LAST);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_angle     = r_angle;
    assign o_moment_x  = r_out_x;
    assign o_moment_y  = r_out_y;

endmodule

FILE: test/patch_orientation_centroid_test.sv
// Self-checking stream testbench for the patch orientation block, with its own moment and CORDIC predictor.
`timescale 1ns / 1ps

module patch_orientation_centroid_test;
    import poc_pkg::*;

    // Predictor constants, kept apart from the design's own
    localparam longint MOMENT_TOP   = 64'sd4194303;
    localparam longint MOMENT_FLOOR = -64'sd4194304;
    localparam longint HALF_TURN    = 64'sd25736;
    localparam longint QUARTER_TURN = 64'sd12868;
    localparam int     CORDIC_ITERS = CORDIC_STEPS_DEF;
    localparam int     HOLD_AT      = 1300;   // pixels taken before the long output hold-off
    localparam int     HOLD_CYCLES  = 500;
    localparam int     RANDOM_ITEMS = 650;

    typedef struct packed {
        logic [7:0]        pixel;
        logic signed [4:0] col;
        logic signed [4:0] row;
        logic              last;
        logic              drain_first;   // hold this request until all results are back
    } t_pixel_req;

    typedef struct packed {
        logic signed [15:0] angle;
        logic signed [22:0] mom_x;
        logic signed [22:0] mom_y;
    } t_orientation;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;     // [7:0] pixel, [12:8] col_offset, [17:13] row_offset
    logic             s_axis_tlast = 1'b0;   // last_pixel
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;          // [15:0] angle, [38:16] moment_x, [61:39] moment_y

    // atan(2^-i) in Q3.13; zero beyond the fifteenth step
    int arctan_q13 [24] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1, 1,
                            0, 0, 0, 0, 0, 0, 0, 0, 0};

    t_pixel_req   pending_pixels [$];
    t_orientation orientations_due [$];

    longint sum_x_acc = 0;
    longint sum_y_acc = 0;

    bit pix_accepted = 1'b0;
    bit res_taken = 1'b0;
    int pixels_taken = 0;
    int results_seen = 0;
    int patches_closed = 0;
    int saturated_patches = 0;
    int zero_vectors = 0;
    int outside_pixels = 0;
    int mismatch_count = 0;

    int src_gap = 0;
    bit src_quiet = 1'b0;
    int sink_gap = 0;
    bit sink_quiet = 1'b0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    t_pixel_req next_req;

    patch_orientation_centroid u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint clamp_moment(input longint v);
        if (v > MOMENT_TOP)
            return MOMENT_TOP;
        if (v < MOMENT_FLOOR)
            return MOMENT_FLOOR;
        return v;
    endfunction

    // Vectoring CORDIC on (mx, my); left-half vectors get a quarter-turn pre-rotation
    function automatic logic signed [15:0] centroid_angle(input longint my, input longint mx);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        int i;
        x = mx;
        y = my;
        z = 0;
        if (mx == 0 && my == 0)
            return 16'sd0;
        if (mx < 0) begin
            if (my >= 0) begin
                x = my;
                y = -mx;
                z = QUARTER_TURN;
            end else begin
                x = -my;
                y = mx;
                z = -QUARTER_TURN;
            end
        end
        for (i = 0; i < CORDIC_ITERS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_q13[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_q13[i];
            end
        end
        if (z > HALF_TURN)
            z = HALF_TURN;
        if (z < -HALF_TURN)
            z = -HALF_TURN;
        return z[15:0];
    endfunction

    // Fold one accepted pixel into the moments; close the patch on its last pixel
    task automatic accumulate_pixel(input logic [7:0] pix, input logic signed [4:0] col,
                                    input logic signed [4:0] row, input logic last);
        longint pv;
        longint cv;
        longint rv;
        longint raw_x;
        longint raw_y;
        t_orientation r;
        pv = longint'(pix);
        cv = longint'(col);
        rv = longint'(row);
        if (cv >= -HALF_PATCH && cv <= HALF_PATCH && rv >= -HALF_PATCH && rv <= HALF_PATCH) begin
            raw_x = sum_x_acc + cv * pv;
            raw_y = sum_y_acc + rv * pv;
            sum_x_acc = clamp_moment(raw_x);
            sum_y_acc = clamp_moment(raw_y);
            if (raw_x != sum_x_acc || raw_y != sum_y_acc)
                saturated_patches++;
        end else begin
            outside_pixels++;
        end
        if (last) begin
            r.angle = centroid_angle(sum_y_acc, sum_x_acc);
            r.mom_x = sum_x_acc[22:0];
            r.mom_y = sum_y_acc[22:0];
            if (sum_x_acc == 0 && sum_y_acc == 0)
                zero_vectors++;
            orientations_due.insert(orientations_due.size(), r);
            patches_closed++;
            sum_x_acc = 0;
            sum_y_acc = 0;
        end
    endtask

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $time, what);
    endtask

    function automatic int pick_idle(input bit quiet);
        int r;
        r = $urandom_range(99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_pixel(input logic [7:0] pix, input logic signed [4:0] col,
                               input logic signed [4:0] row, input logic last,
                               input logic drain);
        t_pixel_req p;
        p.pixel = pix;
        p.col = col;
        p.row = row;
        p.last = last;
        p.drain_first = drain;
        pending_pixels.insert(pending_pixels.size(), p);
    endtask

    // Sample both handshakes at the rising edge; predict and check here
    always @(posedge i_clk) begin
        t_orientation want;
        t_orientation got;
        pix_accepted = i_rst_n && s_axis_tvalid && s_axis_tready;
        res_taken = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (pix_accepted) begin
            accumulate_pixel(s_axis_tdata[7:0], s_axis_tdata[12:8], s_axis_tdata[17:13],
                             s_axis_tlast);
            pixels_taken++;
        end
        if (res_taken) begin
            got.angle = m_axis_tdata[15:0];
            got.mom_x = m_axis_tdata[38:16];
            got.mom_y = m_axis_tdata[61:39];
            results_seen++;
            if (orientations_due.size() == 0) begin
                note_mismatch($sformatf("unexpected result angle %0d moment_x %0d moment_y %0d",
                                        got.angle, got.mom_x, got.mom_y));
            end else begin
                want = orientations_due.pop_front();
                if (got.angle !== want.angle)
                    note_mismatch($sformatf("result %0d angle: expected %0d, got %0d",
                                            results_seen, want.angle, got.angle));
                if (got.mom_x !== want.mom_x)
                    note_mismatch($sformatf("result %0d moment_x: expected %0d, got %0d",
                                            results_seen, want.mom_x, got.mom_x));
                if (got.mom_y !== want.mom_y)
                    note_mismatch($sformatf("result %0d moment_y: expected %0d, got %0d",
                                            results_seen, want.mom_y, got.mom_y));
            end
        end
    end

    // Pixel driver: advance on acceptance, insert random gaps, hold drain-marked requests
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (pix_accepted || !s_axis_tvalid) begin
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_pixels.size() == 0 ||
                         (pending_pixels[0].drain_first && orientations_due.size() != 0)) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                next_req = pending_pixels.pop_front();
                s_axis_tdata <= {6'b0, next_req.row, next_req.col, next_req.pixel};
                s_axis_tlast <= next_req.last;
                s_axis_tvalid <= 1'b1;
                src_gap = pick_idle(src_quiet);
                if ($urandom_range(63) == 0)
                    src_quiet = !src_quiet;
            end
        end
    end

    // Result sink: one long hold-off to back the block up, otherwise random stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && pixels_taken >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (res_taken || $urandom_range(7) == 0)
                sink_gap = pick_idle(sink_quiet);
            if ($urandom_range(63) == 0)
                sink_quiet = !sink_quiet;
        end
    end

    // Stimulus and end of run
    initial begin
        int random_items;
        int len;
        int r;
        int bx;
        int by;
        logic [7:0] pix;
        logic signed [4:0] col;
        logic signed [4:0] row;

        // Directed: zero vector, the four axes, diagonals, offsets outside the patch
        queue_pixel(8'd255, 5'sd0, 5'sd0, 1'b1, 1'b1);
        queue_pixel(8'd255, 5'sd15, 5'sd0, 1'b1, 1'b0);
        queue_pixel(8'd255, -5'sd15, 5'sd0, 1'b1, 1'b0);
        queue_pixel(8'd255, 5'sd0, 5'sd15, 1'b1, 1'b0);
        queue_pixel(8'd255, 5'sd0, -5'sd15, 1'b1, 1'b0);
        queue_pixel(8'd255, -5'sd15, -5'sd15, 1'b1, 1'b0);
        queue_pixel(8'd255, 5'sd15, 5'sd15, 1'b1, 1'b0);
        queue_pixel(8'd0, 5'sd15, 5'sd15, 1'b1, 1'b0);
        queue_pixel(8'd200, -5'sd16, 5'sd3, 1'b1, 1'b0);
        queue_pixel(8'd200, 5'sd3, -5'sd16, 1'b1, 1'b0);
        queue_pixel(8'd255, -5'sd16, -5'sd16, 1'b0, 1'b1);
        queue_pixel(8'd1, 5'sd15, -5'sd15, 1'b0, 1'b0);
        queue_pixel(8'd128, -5'sd1, 5'sd1, 1'b1, 1'b0);
        queue_pixel(8'd1, 5'sd1, 5'sd0, 1'b0, 1'b0);
        queue_pixel(8'd1, -5'sd1, 5'sd0, 1'b1, 1'b0);
        // Just either side of the negative real axis, where the angle clamps
        queue_pixel(8'd255, -5'sd15, -5'sd1, 1'b1, 1'b0);
        queue_pixel(8'd255, -5'sd15, 5'sd1, 1'b1, 1'b0);
        queue_pixel(8'd1, -5'sd15, 5'sd0, 1'b1, 1'b0);

        // Saturate moment_x high and moment_y low, then back off from the rails
        for (int i = 0; i < 1120; i++)
            queue_pixel(8'd255, 5'sd15, -5'sd15, 1'b0, i == 0);
        for (int i = 0; i < 10; i++)
            queue_pixel(8'd255, -5'sd15, 5'sd15, 1'b0, 1'b0);
        queue_pixel(8'd0, 5'sd0, 5'sd0, 1'b1, 1'b0);

        // Random patches with a bright side so angles spread over the whole circle
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            r = $urandom_range(99);
            if (r < 15)
                len = 1;
            else if (r < 85)
                len = $urandom_range(2, 24);
            else
                len = $urandom_range(25, 120);
            bx = $urandom_range(2) - 1;
            by = $urandom_range(2) - 1;
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(9) == 0) begin
                    col = 5'($urandom_range(31));
                    row = 5'($urandom_range(31));
                end else begin
                    col = 5'(int'($urandom_range(30)) - 15);
                    row = 5'(int'($urandom_range(30)) - 15);
                end
                if (col * bx + row * by > 0)
                    pix = 8'($urandom_range(128, 255));
                else
                    pix = 8'($urandom_range(0, 127));
                if ($urandom_range(15) == 0)
                    pix = $urandom_range(1) ? 8'd255 : 8'd0;
                queue_pixel(pix, col, row, i == len - 1, i == 0 && $urandom_range(29) == 0);
            end
            random_items += len;
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_pixels.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        while (orientations_due.size() != 0)
            @(posedge i_clk);
        // Leave room for anything the block might still emit
        repeat (4 * (CORDIC_ITERS + 2)) @(posedge i_clk);

        if (orientations_due.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", orientations_due.size()));
        $display("Streamed %0d pixels (%0d outside the patch radius) in %0d patches.",
                 pixels_taken, outside_pixels, patches_closed);
        $display("Checked %0d results: %0d zero vectors, %0d saturating moment updates.",
                 results_seen, zero_vectors, saturated_patches);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: the slowest correct run is well under a tenth of this
    initial begin
        #5ms;
        $display("Timed out with %0d results outstanding", orientations_due.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: patch_orientation_centroid.f
hw/rtl/poc_pkg.sv
hw/rtl/poc_ctrl.sv
hw/rtl/poc_dp.sv
hw/rtl/patch_orientation_centroid.sv
test/patch_orientation_centroid_test.sv
